// ----- rtl/slt_pkg.sv -----
// Package: types, codes and helpers shared by the shell line tokenizer.
`timescale 1ns / 1ps
package slt_pkg;

  localparam int unsigned MaxLineDefault = 4096;
  localparam int unsigned QueueDepth     = 4;

  localparam logic [7:0] CharPipe   = 8'h7C;
  localparam logic [7:0] CharLess   = 8'h3C;
  localparam logic [7:0] CharMore   = 8'h3E;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_PIPE    = 3'd1,
    KIND_IN      = 3'd2,
    KIND_OUT     = 3'd3,
    KIND_HEREDOC = 3'd4,
    KIND_APPEND  = 3'd5,
    KIND_ERROR   = 3'd6
  } tok_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_QUOTE = 3'd2,
    MODE_OP    = 3'd3,
    MODE_PWORD = 3'd4,
    MODE_POP   = 3'd5,
    MODE_DROP  = 3'd6
  } scan_mode_e;

  // operator codes held in rc_q
  typedef enum logic [1:0] {
    OP_PIPE = 2'd0,
    OP_LESS = 2'd1,
    OP_MORE = 2'd2
  } op_code_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    tok_kind_e   token_kind;
    logic [11:0] token_start;
    logic [12:0] token_length;
    logic        all_quoted;
    logic        last_of_line;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } emit_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == CharPipe) || (c == CharLess) || (c == CharMore);
  endfunction

  function automatic op_code_e op_of(logic [7:0] c);
    op_code_e r;
    if (c == CharPipe) begin
      r = OP_PIPE;
    end else if (c == CharLess) begin
      r = OP_LESS;
    end else begin
      r = OP_MORE;
    end
    return r;
  endfunction

  function automatic tok_kind_e op_kind(op_code_e rc, logic [1:0] cnt);
    tok_kind_e k;
    case (rc)
      OP_PIPE: k = (cnt == 2'd1) ? KIND_PIPE : KIND_ERROR;
      OP_LESS: k = (cnt == 2'd1) ? KIND_IN : KIND_HEREDOC;
      default: k = (cnt == 2'd1) ? KIND_OUT : KIND_APPEND;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/shell_line_tokenizer.sv -----
// Top level: input register, scanner core and result queue.
//
//   channel | direction | payload   | handshake
//   in      | input     | in_item_t | in_valid_i / in_ready_o
//   out     | output    | token_t   | out_valid_o / out_ready_i
//
// One byte per cycle while the queue has room: a byte is registered, then
// scanned, and its tokens (up to two) go into a four-entry result queue.
// A byte is scanned only while the queue has room for two tokens; the queue
// drains one token per cycle, so output stalls back up into in_ready_o.
// rst_ni clears the scanner state, the input register valid and the queue.
`timescale 1ns / 1ps
module shell_line_tokenizer import slt_pkg::*; #(
  parameter int unsigned MaxLine = MaxLineDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output token_t   out_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic     item_vld_q;
  in_item_t item_q;
  logic     scan;
  emit_t    emit_a, emit_b;

  token_t          queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;
  logic [1:0]      n_push;
  token_t          push0;

  assign scan       = item_vld_q && (count_q <= CntW'(QueueDepth - 2));
  assign in_ready_o = !item_vld_q || scan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  slt_core #(
    .MaxLine(MaxLine)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (scan),
    .item_i  (item_q),
    .emit_a_o(emit_a),
    .emit_b_o(emit_b)
  );

  // pack the two emit slots so a lone line-end token goes first
  assign push0  = emit_a.valid ? emit_a.tok : emit_b.tok;
  assign n_push = {1'b0, emit_a.valid} + {1'b0, emit_b.valid};

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = queue_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= push0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= emit_b.tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(n_push) - CntW'(pop);
    end
  end

endmodule

// ----- rtl/slt_core.sv -----
// Scanner state and token decisions for one registered byte per enabled cycle.
`timescale 1ns / 1ps
module slt_core import slt_pkg::*; #(
  parameter int unsigned MaxLine = MaxLineDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  in_item_t item_i,
  output emit_t    emit_a_o,
  output emit_t    emit_b_o
);

  localparam int unsigned PosW = $clog2(MaxLine);
  localparam int unsigned LenW = $clog2(MaxLine + 1);

  scan_mode_e      mode_q, mode_d, mode_m;
  logic            oq_q, oq_d, oq_m;
  op_code_e        rc_q, rc_d, rc_m;
  logic [1:0]      cnt_q, cnt_d, cnt_m;
  logic [LenW-1:0] len_q, len_d, len_m, len_grow;
  logic [PosW-1:0] start_q, start_d, start_m;
  logic            saw_q, saw_d, saw_m;
  logic [PosW-1:0] pos_q, pos_d;

  logic [7:0] c;
  logic       blank, opc, quote, do_start;
  logic [1:0] cnt_inc;

  function automatic logic [11:0] fit_start(logic [PosW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[11:0];
  endfunction

  function automatic logic [12:0] fit_len(logic [LenW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[12:0];
  endfunction

  always_comb begin
    c        = item_i.char_in;
    blank    = is_blank(c);
    opc      = is_op(c);
    quote    = (c == CharSquote) || (c == CharDquote);
    len_grow = (len_q < LenW'(MaxLine)) ? len_q + LenW'(1) : len_q;
    cnt_inc  = cnt_q + 2'd1;

    mode_m   = mode_q;
    oq_m     = oq_q;
    rc_m     = rc_q;
    cnt_m    = cnt_q;
    len_m    = len_q;
    start_m  = start_q;
    saw_m    = saw_q;
    do_start = 1'b0;

    emit_a_o = '0;
    emit_b_o = '0;
    // token held in the current state, used when a new token begins
    emit_a_o.tok.token_start  = fit_start(start_q);
    emit_a_o.tok.token_length = fit_len(len_q);
    if ((mode_q == MODE_WORD) || (mode_q == MODE_PWORD)) begin
      emit_a_o.tok.token_kind = KIND_WORD;
      emit_a_o.tok.all_quoted = ~saw_q;
    end else begin
      emit_a_o.tok.token_kind = op_kind(rc_q, cnt_q);
      emit_a_o.tok.all_quoted = 1'b0;
    end

    case (mode_q)
      MODE_WORD: begin
        if (blank) begin
          mode_m = MODE_PWORD;
        end else if (opc) begin
          emit_a_o.valid = 1'b1;
          do_start       = 1'b1;
        end else if (quote) begin
          len_m  = len_grow;
          oq_m   = (c == CharDquote);
          mode_m = MODE_QUOTE;
        end else begin
          len_m = len_grow;
          saw_m = 1'b1;
        end
      end
      MODE_QUOTE: begin
        len_m = len_grow;
        if (c == (oq_q ? CharDquote : CharSquote)) begin
          mode_m = MODE_WORD;
        end
      end
      MODE_OP: begin
        if (blank) begin
          mode_m = MODE_POP;
        end else if (opc && (op_of(c) == rc_q)) begin
          len_m = len_grow;
          cnt_m = cnt_inc;
          // doubled pipe or tripled redirection
          if (((rc_q == OP_PIPE) && (cnt_inc >= 2'd2)) || (cnt_inc >= 2'd3)) begin
            emit_a_o.valid             = 1'b1;
            emit_a_o.tok.token_kind    = KIND_ERROR;
            emit_a_o.tok.token_length  = fit_len(len_grow);
            emit_a_o.tok.last_of_line  = 1'b1;
            mode_m                     = MODE_DROP;
          end
        end else begin
          emit_a_o.valid = 1'b1;
          do_start       = 1'b1;
        end
      end
      MODE_DROP: begin
      end
      default: begin
        if (!blank) begin
          emit_a_o.valid = (mode_q == MODE_PWORD) || (mode_q == MODE_POP);
          do_start       = 1'b1;
        end
      end
    endcase

    if (do_start) begin
      start_m = pos_q;
      len_m   = LenW'(1);
      saw_m   = 1'b0;
      if (opc) begin
        mode_m = MODE_OP;
        rc_m   = op_of(c);
        cnt_m  = 2'd1;
      end else if (quote) begin
        mode_m = MODE_QUOTE;
        oq_m   = (c == CharDquote);
      end else begin
        mode_m = MODE_WORD;
        saw_m  = 1'b1;
      end
    end

    // line end flushes whatever token is open after this byte
    emit_b_o.tok.token_start  = fit_start(start_m);
    emit_b_o.tok.token_length = fit_len(len_m);
    emit_b_o.tok.last_of_line = 1'b1;
    if ((mode_m == MODE_WORD) || (mode_m == MODE_PWORD)) begin
      emit_b_o.tok.token_kind = KIND_WORD;
      emit_b_o.tok.all_quoted = ~saw_m;
    end else if (mode_m == MODE_QUOTE) begin
      emit_b_o.tok.token_kind = KIND_ERROR;
    end else begin
      emit_b_o.tok.token_kind = op_kind(rc_m, cnt_m);
    end
    emit_b_o.valid = item_i.line_end && (mode_m != MODE_IDLE) && (mode_m != MODE_DROP);

    if (item_i.line_end) begin
      mode_d  = MODE_IDLE;
      oq_d    = 1'b0;
      rc_d    = OP_PIPE;
      cnt_d   = 2'd0;
      len_d   = '0;
      start_d = '0;
      saw_d   = 1'b0;
      pos_d   = '0;
    end else begin
      mode_d  = mode_m;
      oq_d    = oq_m;
      rc_d    = rc_m;
      cnt_d   = cnt_m;
      len_d   = len_m;
      start_d = start_m;
      saw_d   = saw_m;
      pos_d   = (pos_q < PosW'(MaxLine - 1)) ? pos_q + PosW'(1) : pos_q;
    end

    if (!en_i) begin
      emit_a_o.valid = 1'b0;
      emit_b_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      oq_q    <= 1'b0;
      rc_q    <= OP_PIPE;
      cnt_q   <= 2'd0;
      len_q   <= '0;
      start_q <= '0;
      saw_q   <= 1'b0;
      pos_q   <= '0;
    end else if (en_i) begin
      mode_q  <= mode_d;
      oq_q    <= oq_d;
      rc_q    <= rc_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      start_q <= start_d;
      saw_q   <= saw_d;
      pos_q   <= pos_d;
    end
  end

endmodule
